// File: design/tmcw_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the text console writer.
// No dependencies; used by every module of the block by scoped names.
package tmcw_pkg;

  // Input operation codes
  localparam logic [1:0] OP_PUT   = 2'd0;
  localparam logic [1:0] OP_CLEAR = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  // Control characters
  localparam logic [7:0] CH_BACKSPACE = 8'd8;
  localparam logic [7:0] CH_NEWLINE   = 8'd10;
  localparam logic [7:0] CH_RETURN    = 8'd13;
  localparam logic [7:0] CH_SPACE     = 8'd32;

  localparam logic [7:0] RESET_ATTR  = 8'h0F;
  localparam logic [7:0] RESET_COLOR = 8'd15;

  // Configuration register word index
  localparam logic REG_TEXT_COLOR = 1'b0;

  // Field widths
  localparam int OP_W      = 2;
  localparam int CHAR_W    = 8;
  localparam int INDEX_W   = 11;
  localparam int ENTRY_W   = 16;
  localparam int ROW_FW    = 5;
  localparam int COL_FW    = 7;
  localparam int POS_FW    = 11;

  // Classified command kinds
  localparam int KIND_W = 3;
  localparam logic [KIND_W-1:0] CMD_PRINT     = 3'd0;
  localparam logic [KIND_W-1:0] CMD_NEWLINE   = 3'd1;
  localparam logic [KIND_W-1:0] CMD_RETURN    = 3'd2;
  localparam logic [KIND_W-1:0] CMD_BACKSPACE = 3'd3;
  localparam logic [KIND_W-1:0] CMD_CLEAR     = 3'd4;
  localparam logic [KIND_W-1:0] CMD_READ      = 3'd5;
  localparam logic [KIND_W-1:0] CMD_NOP       = 3'd6;

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [CHAR_W-1:0]  ch;
    logic [INDEX_W-1:0] idx;
  } cmd_t;

  typedef struct packed {
    logic clearing;
  } back_status_t;

endpackage

// File: design/tmcw_front.sv
`timescale 1ns / 1ps
// Front end: accepts input beats, classifies them into commands, and
// pushes them to the command queue. Depends on tmcw_pkg.
module tmcw_front (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [tmcw_pkg::OP_W-1:0]       operation,
  input  logic [tmcw_pkg::CHAR_W-1:0]     char_code,
  input  logic [tmcw_pkg::INDEX_W-1:0]    cell_index,
  input  tmcw_pkg::back_status_t          status,
  input  logic                            q_full,
  output logic                            push,
  output tmcw_pkg::cmd_t                  push_cmd
);

  logic           front_valid;
  tmcw_pkg::cmd_t front_cmd;
  tmcw_pkg::cmd_t classified;
  logic           accept;

  always_comb begin
    classified.ch  = char_code;
    classified.idx = cell_index;
    case (operation)
      tmcw_pkg::OP_PUT: begin
        case (char_code)
          tmcw_pkg::CH_NEWLINE:   classified.kind = tmcw_pkg::CMD_NEWLINE;
          tmcw_pkg::CH_RETURN:    classified.kind = tmcw_pkg::CMD_RETURN;
          tmcw_pkg::CH_BACKSPACE: classified.kind = tmcw_pkg::CMD_BACKSPACE;
          default:                classified.kind = tmcw_pkg::CMD_PRINT;
        endcase
      end
      tmcw_pkg::OP_CLEAR: classified.kind = tmcw_pkg::CMD_CLEAR;
      tmcw_pkg::OP_READ:  classified.kind = tmcw_pkg::CMD_READ;
      default:            classified.kind = tmcw_pkg::CMD_NOP;
    endcase
  end

  // hold off input during the power-up clearing pass and while a full queue blocks the front register
  assign in_stall = status.clearing || (front_valid && q_full);
  assign accept   = in_valid && !in_stall;
  assign push     = front_valid && !q_full;
  assign push_cmd = front_cmd;

  always_ff @(posedge clk) begin
    if (rst) begin
      front_valid <= 1'b0;
    end else if (accept) begin
      front_valid <= 1'b1;
    end else if (push) begin
      front_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      front_cmd <= classified;
    end
  end

endmodule

// File: design/tmcw_queue.sv
`timescale 1ns / 1ps
// Two-entry command queue between front and back end.
// Depends on tmcw_pkg for the command type.
module tmcw_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  tmcw_pkg::cmd_t push_cmd,
  output logic           full,
  input  logic           pop,
  output logic           not_empty,
  output tmcw_pkg::cmd_t head
);

  localparam int Depth = 2;
  localparam int PtrW  = $clog2(Depth);
  localparam int CntW  = $clog2(Depth + 1);

  tmcw_pkg::cmd_t  slots [Depth];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;

  assign full      = (count == CntW'(Depth));
  assign not_empty = (count != '0);
  assign head      = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

endmodule

// File: design/tmcw_back.sv
`timescale 1ns / 1ps
// Back end: cursor state, screen memory with a rotating row base, blanking
// sequencer for clear and scroll, and the result register. Uses tmcw_pkg.
module tmcw_back #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic [7:0]                       text_color,
  input  logic                             q_valid,
  input  tmcw_pkg::cmd_t                   q_cmd,
  output logic                             q_pop,
  output tmcw_pkg::back_status_t           status,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [tmcw_pkg::ENTRY_W-1:0]     read_entry,
  output logic [tmcw_pkg::ROW_FW-1:0]      cursor_row,
  output logic [tmcw_pkg::COL_FW-1:0]      cursor_column,
  output logic [tmcw_pkg::POS_FW-1:0]      cursor_position,
  output logic                             scrolled
);

  localparam int CellCount = ROWS * COLUMNS;
  localparam int CW        = $clog2(COLUMNS);
  localparam int RW        = $clog2(ROWS);
  localparam int PW        = $clog2(CellCount);
  localparam int PW1       = PW + 1;
  localparam int RowFW     = tmcw_pkg::ROW_FW;
  localparam int ColFW     = tmcw_pkg::COL_FW;
  localparam int PosFW     = tmcw_pkg::POS_FW;
  localparam int EntryW    = tmcw_pkg::ENTRY_W;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_READ = 2'd1;
  localparam logic [1:0] S_FILL = 2'd2;

  logic [1:0]        state, state_next;
  logic [RW-1:0]     row, row_next;
  logic [CW-1:0]     col, col_next;
  logic [PW-1:0]     pos, pos_next;
  logic [PW-1:0]     base, base_next;
  logic [PW-1:0]     fill_addr, fill_addr_next;
  logic [PW-1:0]     fill_end, fill_end_next;
  logic [7:0]        fill_attr, fill_attr_next;
  logic              clearing, clearing_next;

  logic [EntryW-1:0] mem [CellCount];
  logic              we;
  logic [PW-1:0]     waddr;
  logic [EntryW-1:0] wdata;
  logic              rd_en;
  logic [PW-1:0]     raddr;
  logic [EntryW-1:0] rdata;

  logic              out_free;
  logic              out_load;
  logic [EntryW-1:0] ld_entry;
  logic              ld_scrolled;
  logic              col_last;
  logic              row_last;
  logic [PW-1:0]     row_start;

  // logical cell offset to physical address under the rotating row base
  function automatic logic [PW-1:0] phys(input logic [PW-1:0] a,
                                         input logic [PW-1:0] b);
    logic [PW1-1:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= PW1'(CellCount)) begin
      s = s - PW1'(CellCount);
    end
    return s[PW-1:0];
  endfunction

  assign out_free  = !out_valid || !out_stall;
  assign col_last  = (col == CW'(COLUMNS - 1));
  assign row_last  = (row == RW'(ROWS - 1));
  assign row_start = pos - PW'(col);
  assign status.clearing = clearing;

  always_comb begin
    state_next     = state;
    row_next       = row;
    col_next       = col;
    pos_next       = pos;
    base_next      = base;
    fill_addr_next = fill_addr;
    fill_end_next  = fill_end;
    fill_attr_next = fill_attr;
    clearing_next  = clearing;
    we             = 1'b0;
    waddr          = phys(pos, base);
    wdata          = {text_color, q_cmd.ch};
    rd_en          = 1'b0;
    raddr          = phys(PW'(q_cmd.idx), base);
    q_pop          = 1'b0;
    out_load       = 1'b0;
    ld_entry       = '0;
    ld_scrolled    = 1'b0;

    case (state)
      S_IDLE: begin
        if (q_valid && out_free) begin
          q_pop    = 1'b1;
          out_load = 1'b1;
          case (q_cmd.kind)
            tmcw_pkg::CMD_PRINT: begin
              we       = 1'b1;
              pos_next = pos + 1'b1;
              if (col_last) begin
                col_next = '0;
                if (row_last) begin
                  ld_scrolled = 1'b1;
                  pos_next    = row_start;
                end else begin
                  row_next = row + 1'b1;
                end
              end else begin
                col_next = col + 1'b1;
              end
            end
            tmcw_pkg::CMD_NEWLINE: begin
              col_next = '0;
              if (row_last) begin
                ld_scrolled = 1'b1;
                pos_next    = row_start;
              end else begin
                row_next = row + 1'b1;
                pos_next = row_start + PW'(COLUMNS);
              end
            end
            tmcw_pkg::CMD_RETURN: begin
              col_next = '0;
              pos_next = row_start;
            end
            tmcw_pkg::CMD_BACKSPACE: begin
              // both the in-row step and the wrap move one cell back
              if (col != '0 || row != '0) begin
                we       = 1'b1;
                waddr    = phys(pos - 1'b1, base);
                wdata    = {text_color, tmcw_pkg::CH_SPACE};
                pos_next = pos - 1'b1;
                if (col != '0) begin
                  col_next = col - 1'b1;
                end else begin
                  row_next = row - 1'b1;
                  col_next = CW'(COLUMNS - 1);
                end
              end
            end
            tmcw_pkg::CMD_CLEAR: begin
              row_next       = '0;
              col_next       = '0;
              pos_next       = '0;
              base_next      = '0;
              fill_addr_next = '0;
              fill_end_next  = PW'(CellCount - 1);
              fill_attr_next = text_color;
              state_next     = S_FILL;
            end
            tmcw_pkg::CMD_READ: begin
              if (32'(q_cmd.idx) < CellCount) begin
                rd_en      = 1'b1;
                out_load   = 1'b0;
                state_next = S_READ;
              end
            end
            default: begin
            end
          endcase
          // scroll: advance the row base and blank the old top row,
          // which now serves as the bottom row
          if (ld_scrolled) begin
            base_next      = (base == PW'(CellCount - COLUMNS)) ? '0
                                                               : base + PW'(COLUMNS);
            fill_addr_next = base;
            fill_end_next  = base + PW'(COLUMNS - 1);
            fill_attr_next = text_color;
            state_next     = S_FILL;
          end
        end
      end
      S_READ: begin
        out_load   = 1'b1;
        ld_entry   = rdata;
        state_next = S_IDLE;
      end
      S_FILL: begin
        we             = 1'b1;
        waddr          = fill_addr;
        wdata          = {fill_attr, tmcw_pkg::CH_SPACE};
        fill_addr_next = fill_addr + 1'b1;
        if (fill_addr == fill_end) begin
          clearing_next = 1'b0;
          state_next    = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_FILL;
      row       <= '0;
      col       <= '0;
      pos       <= '0;
      base      <= '0;
      fill_addr <= '0;
      fill_end  <= PW'(CellCount - 1);
      fill_attr <= tmcw_pkg::RESET_ATTR;
      clearing  <= 1'b1;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      row       <= row_next;
      col       <= col_next;
      pos       <= pos_next;
      base      <= base_next;
      fill_addr <= fill_addr_next;
      fill_end  <= fill_end_next;
      fill_attr <= fill_attr_next;
      clearing  <= clearing_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      read_entry      <= ld_entry;
      cursor_row      <= RowFW'(row_next);
      cursor_column   <= ColFW'(col_next);
      cursor_position <= PosFW'(pos_next);
      scrolled        <= ld_scrolled;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: design/text_mode_console_writer.sv
`timescale 1ns / 1ps
// Text console writer: an input beat passes the front register, a queue slot and the
// result register for put, clear and unused codes; an in-range read adds one registered
// screen-memory read. The back end takes one command per cycle while idle and its result
// register is free; a read holds it in S_READ, a scroll or a clear in S_FILL while the
// blanking runs. After reset a clearing pass fills the screen memory with blanks in
// attribute 0x0F; in_stall stays high until it ends.
module text_mode_console_writer #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [2:0]                    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [tmcw_pkg::OP_W-1:0]     operation,
  input  logic [tmcw_pkg::CHAR_W-1:0]   char_code,
  input  logic [tmcw_pkg::INDEX_W-1:0]  cell_index,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [tmcw_pkg::ENTRY_W-1:0]  read_entry,
  output logic [tmcw_pkg::ROW_FW-1:0]   cursor_row,
  output logic [tmcw_pkg::COL_FW-1:0]   cursor_column,
  output logic [tmcw_pkg::POS_FW-1:0]   cursor_position,
  output logic                          scrolled
);

  logic [7:0]             text_color;
  tmcw_pkg::back_status_t status;
  tmcw_pkg::cmd_t         push_cmd;
  tmcw_pkg::cmd_t         head;
  logic                   push;
  logic                   q_full;
  logic                   q_valid;
  logic                   q_pop;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      text_color <= tmcw_pkg::RESET_COLOR;
    end else if (psel && penable && pwrite && paddr[2] == tmcw_pkg::REG_TEXT_COLOR) begin
      text_color <= pwdata[7:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == tmcw_pkg::REG_TEXT_COLOR) begin
      prdata = {24'd0, text_color};
    end
  end

  tmcw_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .operation  (operation),
    .char_code  (char_code),
    .cell_index (cell_index),
    .status     (status),
    .q_full     (q_full),
    .push       (push),
    .push_cmd   (push_cmd)
  );

  tmcw_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_cmd  (push_cmd),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_valid),
    .head      (head)
  );

  tmcw_back #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_back (
    .clk             (clk),
    .rst             (rst),
    .text_color      (text_color),
    .q_valid         (q_valid),
    .q_cmd           (head),
    .q_pop           (q_pop),
    .status          (status),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .read_entry      (read_entry),
    .cursor_row      (cursor_row),
    .cursor_column   (cursor_column),
    .cursor_position (cursor_position),
    .scrolled        (scrolled)
  );

`ifndef SYNTHESIS
  // no input beat may slip in while the screen memory is being initialized
  assert property (@(posedge clk) disable iff (rst) status.clearing |-> in_stall)
    else $error("input accepted during clearing pass");

  // a scroll always leaves the cursor at the start of a line
  assert property (@(posedge clk) disable iff (rst)
    out_valid && scrolled |-> cursor_column == '0)
    else $error("scroll result with nonzero column");

  // the queue is never popped while empty
  assert property (@(posedge clk) disable iff (rst) q_pop |-> q_valid)
    else $error("command queue popped while empty");
`endif

endmodule
